// File: rtl/mla_pkg.sv
// Shared types and constants for the linear mouse acceleration block.
// Holds the sequencer state type and the arithmetic unit's command type.
// Depends on nothing; every other file imports it.
package mla_pkg;

   localparam int unsigned NUM_REGS = 8;
   localparam int unsigned CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PRE_SCALE_X  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PRE_SCALE_Y  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPEED_CAP    = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RATE_OFFSET  = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ACCEL_RATIO  = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_CAP     = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POST_SCALE_X = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POST_SCALE_Y = 4'd7;

   typedef enum logic [1:0] {
      ARITH_MUL,
      ARITH_DIV,
      ARITH_SQRT
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DX,
      ST_MUL_DY,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQRT,
      ST_CAP_MUL_X,
      ST_CAP_DIV_X,
      ST_CAP_MUL_Y,
      ST_CAP_DIV_Y,
      ST_RATE,
      ST_GAIN,
      ST_AX_GAIN,
      ST_AX_POST,
      ST_AX_SUM,
      ST_AX_ROUND
   } seq_state_type;

endpackage

// File: rtl/mouse_linear_acceleration_top.sv
// Linear mouse acceleration with sub-count carry, top level.
// Uses mla_pkg and the bit-serial unit mla_arith.
//
// A transaction takes longer when the rate exceeds rate_offset and longer again when the
// speed cap is engaged. Every multiply, divide and the square root run one after another
// through the single bit-serial unit mla_arith. req_ready is high only while the sequencer
// is idle; a finished result waits in the output register and the next transaction can be
// accepted while it does.
module mouse_linear_acceleration_top #(
   parameter int FRAC_BITS       = 16,
   parameter int MAX_INTERVAL_MS = 100
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [15:0]                  req_move_x,
   input  logic signed [15:0]                  req_move_y,
   input  logic [15:0]                         req_elapsed_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [15:0]                  rsp_out_x,
   output logic signed [15:0]                  rsp_out_y,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mla_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [31:0]                         csr_data
);
   import mla_pkg::*;

   localparam int CW = FRAC_BITS + 2;
   localparam logic [63:0] ONE_Q  = 64'd1 << FRAC_BITS;
   localparam logic [65:0] HALF_Q = 66'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] AXIS_LIMIT = 64'd1 << 62;
   localparam logic [15:0] MAX_MS = 16'(MAX_INTERVAL_MS);

   function automatic logic [63:0] mulq(input logic [127:0] p);
      logic [63:0] r;
      if ((p >> (64 + FRAC_BITS)) != 128'd0) begin
         r = '1;
      end else begin
         r = 64'(p >> FRAC_BITS);
      end
      return r;
   endfunction

   seq_state_type state_ff, state_in;
   logic [31:0]   reg_ff [NUM_REGS];
   logic          launched_ff, launched_in;
   logic          axis_ff;
   logic          neg_x_ff, neg_y_ff;
   logic [16:0]   ax_ff, ay_ff;
   logic [6:0]    ms_ff;
   logic [6:0]    last_interval_ff;
   logic [63:0]   dx_ff, dy_ff, m_ff, rate_ff, gain_ff, v_ff;
   logic [127:0]  sum_ff, scratch_ff;
   logic signed [65:0] t_ff;
   logic signed [CW-1:0] carry_x_ff, carry_y_ff;
   logic          rsp_valid_ff;
   logic signed [15:0] out_x_ff, out_y_ff, hold_x_ff;

   arith_cmd_type cmd;
   logic [127:0]  opnd_a;
   logic [63:0]   opnd_b;
   logic [127:0]  arith_result;
   logic          arith_done;

   logic          req_fire;
   logic          out_free;
   logic          round_go;
   logic          cap_on;
   logic [15:0]   ms_a, ms_b, ms_c;
   logic [63:0]   gain_raw, gain_capped, inc, v_clamped;
   logic signed [65:0] t_calc, carry_ext, r_signed, carry_calc;
   logic [65:0]   abs_t, ra;
   logic signed [15:0] r_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign round_go  = (state_ff == ST_AX_ROUND) && (!axis_ff || out_free);
   assign cap_on    = (reg_ff[REG_SPEED_CAP[2:0]] != 32'd0)
                      && (arith_result[63:0] >= {32'd0, reg_ff[REG_SPEED_CAP[2:0]]});

   // Interval: an unknown interval reuses the last one, long ones are clipped.
   always_comb begin
      ms_a = (req_elapsed_ms == 16'd0) ? {9'd0, last_interval_ff} : req_elapsed_ms;
      ms_b = (ms_a > MAX_MS) ? MAX_MS : ms_a;
      ms_c = (ms_b == 16'd0) ? 16'd1 : ms_b;
   end

   // Gain from the unit result or unity, then the optional cap.
   always_comb begin
      inc      = mulq(arith_result);
      gain_raw = ONE_Q;
      if (state_ff == ST_GAIN) begin
         gain_raw = (inc > ~ONE_Q) ? '1 : ONE_Q + inc;
      end
      gain_capped = gain_raw;
      if (reg_ff[REG_GAIN_CAP[2:0]] != 32'd0
          && gain_raw >= {32'd0, reg_ff[REG_GAIN_CAP[2:0]]}) begin
         gain_capped = {32'd0, reg_ff[REG_GAIN_CAP[2:0]]};
      end
   end

   // Rounding half away from zero, carry kept from the unsaturated count.
   always_comb begin
      v_clamped = (v_ff > AXIS_LIMIT) ? AXIS_LIMIT : v_ff;
      carry_ext = axis_ff ? 66'(carry_y_ff) : 66'(carry_x_ff);
      t_calc    = ((axis_ff ? neg_y_ff : neg_x_ff) ? -$signed({2'd0, v_clamped})
                                                   : $signed({2'd0, v_clamped})) + carry_ext;
      abs_t      = t_ff[65] ? 66'(-t_ff) : 66'(t_ff);
      ra         = (abs_t + HALF_Q) >> FRAC_BITS;
      r_signed   = t_ff[65] ? -$signed(ra) : $signed(ra);
      carry_calc = t_ff - (r_signed <<< FRAC_BITS);
      if (r_signed > 66'sd32767) begin
         r_sat = 16'sh7fff;
      end else if (r_signed < -66'sd32768) begin
         r_sat = -16'sh8000;
      end else begin
         r_sat = 16'(r_signed);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_fire) state_in = ST_MUL_DX;
         ST_MUL_DX:    if (arith_done) state_in = ST_MUL_DY;
         ST_MUL_DY:    if (arith_done) state_in = ST_SQ_X;
         ST_SQ_X:      if (arith_done) state_in = ST_SQ_Y;
         ST_SQ_Y:      if (arith_done) state_in = ST_SQRT;
         ST_SQRT:      if (arith_done) state_in = cap_on ? ST_CAP_MUL_X : ST_RATE;
         ST_CAP_MUL_X: if (arith_done) state_in = ST_CAP_DIV_X;
         ST_CAP_DIV_X: if (arith_done) state_in = ST_CAP_MUL_Y;
         ST_CAP_MUL_Y: if (arith_done) state_in = ST_CAP_DIV_Y;
         ST_CAP_DIV_Y: if (arith_done) state_in = ST_RATE;
         ST_RATE: begin
            if (arith_done) begin
               state_in = (arith_result[63:0] > {32'd0, reg_ff[REG_RATE_OFFSET[2:0]]})
                          ? ST_GAIN : ST_AX_GAIN;
            end
         end
         ST_GAIN:      if (arith_done) state_in = ST_AX_GAIN;
         ST_AX_GAIN:   if (arith_done) state_in = ST_AX_POST;
         ST_AX_POST:   if (arith_done) state_in = ST_AX_SUM;
         ST_AX_SUM:    state_in = ST_AX_ROUND;
         ST_AX_ROUND:  if (round_go) state_in = axis_ff ? ST_IDLE : ST_AX_GAIN;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Unit command and operands.
   always_comb begin
      cmd.start = 1'b0;
      cmd.op    = ARITH_MUL;
      opnd_a    = '0;
      opnd_b    = '0;
      unique case (state_ff)
         ST_IDLE, ST_AX_SUM, ST_AX_ROUND: cmd.start = 1'b0;
         ST_MUL_DX: begin
            opnd_a = {111'd0, ax_ff};
            opnd_b = {32'd0, reg_ff[REG_PRE_SCALE_X[2:0]]};
         end
         ST_MUL_DY: begin
            opnd_a = {111'd0, ay_ff};
            opnd_b = {32'd0, reg_ff[REG_PRE_SCALE_Y[2:0]]};
         end
         ST_SQ_X: begin
            opnd_a = {64'd0, dx_ff};
            opnd_b = dx_ff;
         end
         ST_SQ_Y: begin
            opnd_a = {64'd0, dy_ff};
            opnd_b = dy_ff;
         end
         ST_SQRT: begin
            cmd.op = ARITH_SQRT;
            opnd_a = sum_ff;
         end
         ST_CAP_MUL_X: begin
            opnd_a = {64'd0, dx_ff};
            opnd_b = {32'd0, reg_ff[REG_SPEED_CAP[2:0]]};
         end
         ST_CAP_MUL_Y: begin
            opnd_a = {64'd0, dy_ff};
            opnd_b = {32'd0, reg_ff[REG_SPEED_CAP[2:0]]};
         end
         ST_CAP_DIV_X, ST_CAP_DIV_Y: begin
            cmd.op = ARITH_DIV;
            opnd_a = scratch_ff;
            opnd_b = m_ff;
         end
         ST_RATE: begin
            cmd.op = ARITH_DIV;
            opnd_a = {64'd0, m_ff};
            opnd_b = {57'd0, ms_ff};
         end
         ST_GAIN: begin
            opnd_a = {96'd0, reg_ff[REG_ACCEL_RATIO[2:0]]};
            opnd_b = rate_ff - {32'd0, reg_ff[REG_RATE_OFFSET[2:0]]};
         end
         ST_AX_GAIN: begin
            opnd_a = {64'd0, axis_ff ? dy_ff : dx_ff};
            opnd_b = gain_ff;
         end
         ST_AX_POST: begin
            opnd_a = {64'd0, v_ff};
            opnd_b = {32'd0, axis_ff ? reg_ff[REG_POST_SCALE_Y[2:0]]
                                     : reg_ff[REG_POST_SCALE_X[2:0]]};
         end
         default: cmd.start = 1'b0;
      endcase
      if (state_ff != ST_IDLE && state_ff != ST_AX_SUM && state_ff != ST_AX_ROUND) begin
         cmd.start = !launched_ff;
      end
   end

   always_comb begin
      launched_in = launched_ff;
      if (cmd.start) begin
         launched_in = 1'b1;
      end
      if (arith_done) begin
         launched_in = 1'b0;
      end
   end

   mla_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .result (arith_result),
      .done   (arith_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         launched_ff      <= 1'b0;
         last_interval_ff <= 7'd1;
         carry_x_ff       <= '0;
         carry_y_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         reg_ff[REG_PRE_SCALE_X[2:0]]  <= 32'(ONE_Q);
         reg_ff[REG_PRE_SCALE_Y[2:0]]  <= 32'(ONE_Q);
         reg_ff[REG_SPEED_CAP[2:0]]    <= '0;
         reg_ff[REG_RATE_OFFSET[2:0]]  <= '0;
         reg_ff[REG_ACCEL_RATIO[2:0]]  <= '0;
         reg_ff[REG_GAIN_CAP[2:0]]     <= '0;
         reg_ff[REG_POST_SCALE_X[2:0]] <= 32'(ONE_Q);
         reg_ff[REG_POST_SCALE_Y[2:0]] <= 32'(ONE_Q);
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
         if (csr_valid && csr_ready && csr_index < CSR_INDEX_BITS'(NUM_REGS)) begin
            reg_ff[csr_index[2:0]] <= csr_data;
         end
         if (req_fire) begin
            last_interval_ff <= ms_c[6:0];
         end
         if (round_go) begin
            if (axis_ff) begin
               carry_y_ff <= CW'(carry_calc);
            end else begin
               carry_x_ff <= CW'(carry_calc);
            end
         end
         if (round_go && axis_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // Datapath registers.
      if (req_fire) begin
         neg_x_ff <= req_move_x[15];
         neg_y_ff <= req_move_y[15];
         ax_ff    <= req_move_x[15] ? 17'h10000 - {1'b0, req_move_x} : {1'b0, req_move_x};
         ay_ff    <= req_move_y[15] ? 17'h10000 - {1'b0, req_move_y} : {1'b0, req_move_y};
         ms_ff    <= ms_c[6:0];
         axis_ff  <= 1'b0;
      end
      if (arith_done) begin
         unique case (state_ff)
            ST_MUL_DX:    dx_ff <= arith_result[63:0];
            ST_MUL_DY:    dy_ff <= arith_result[63:0];
            ST_SQ_X:      sum_ff <= arith_result;
            ST_SQ_Y:      sum_ff <= sum_ff + arith_result;
            ST_SQRT:      m_ff <= arith_result[63:0];
            ST_CAP_MUL_X, ST_CAP_MUL_Y: scratch_ff <= arith_result;
            ST_CAP_DIV_X: dx_ff <= arith_result[63:0];
            ST_CAP_DIV_Y: dy_ff <= arith_result[63:0];
            ST_RATE: begin
               rate_ff <= arith_result[63:0];
               gain_ff <= gain_capped;
            end
            ST_GAIN:      gain_ff <= gain_capped;
            ST_AX_GAIN, ST_AX_POST: v_ff <= mulq(arith_result);
            default:      v_ff <= v_ff;
         endcase
      end
      if (state_ff == ST_AX_SUM) begin
         t_ff <= t_calc;
      end
      if (round_go) begin
         if (axis_ff) begin
            out_x_ff <= hold_x_ff;
            out_y_ff <= r_sat;
         end else begin
            hold_x_ff <= r_sat;
            axis_ff   <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;

   a_interval_nonzero: assert property (@(posedge clock) disable iff (reset)
      last_interval_ff != 7'd0)
      else $error("stored interval is zero");
   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> state_ff != ST_IDLE && launched_ff)
      else $error("arith result arrived with no operation outstanding");
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(out_x_ff) && $stable(out_y_ff))
      else $error("pending result was overwritten");

endmodule

// File: rtl/mla_arith.sv
// Bit-serial arithmetic unit: 64x64 multiply, 128/64 divide, 128-bit square root.
// One bit (two radicand bits for the root) is handled per clock cycle.
// Depends on mla_pkg.
module mla_arith (
   input  logic                  clock,
   input  logic                  reset,
   input  mla_pkg::arith_cmd_type cmd,
   input  logic [127:0]          opnd_a,
   input  logic [63:0]           opnd_b,
   output logic [127:0]          result,
   output logic                  done
);
   import mla_pkg::*;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   arith_op_type op_ff, op_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  mcand_ff, mcand_in;
   logic [63:0]  mplier_ff, mplier_in;
   logic [67:0]  rem_ff, rem_in;

   logic [67:0]  shifted;
   logic [67:0]  trial;
   logic         last;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      shifted   = '0;
      trial     = '0;
      last      = 1'b0;
      if (!busy_ff) begin
         if (cmd.start) begin
            busy_in   = 1'b1;
            op_in     = cmd.op;
            cnt_in    = '0;
            rem_in    = '0;
            mcand_in  = opnd_b;
            mplier_in = '0;
            acc_in    = opnd_a;
            if (cmd.op == ARITH_MUL) begin
               acc_in    = '0;
               mcand_in  = opnd_a[63:0];
               mplier_in = opnd_b;
            end
         end
      end else begin
         unique case (op_ff)
            ARITH_MUL: begin
               acc_in    = (acc_ff << 1) + (mplier_ff[63] ? {64'd0, mcand_ff} : 128'd0);
               mplier_in = mplier_ff << 1;
               last      = (cnt_ff == 7'd63);
            end
            ARITH_DIV: begin
               // Restoring division; only the low 64 quotient bits are kept.
               shifted = {rem_ff[66:0], acc_ff[127]};
               acc_in  = acc_ff << 1;
               trial   = {4'd0, mcand_ff};
               if (shifted >= trial) begin
                  rem_in    = shifted - trial;
                  mplier_in = {mplier_ff[62:0], 1'b1};
               end else begin
                  rem_in    = shifted;
                  mplier_in = {mplier_ff[62:0], 1'b0};
               end
               last = (cnt_ff == 7'd127);
            end
            ARITH_SQRT: begin
               shifted = {rem_ff[65:0], acc_ff[127:126]};
               acc_in  = acc_ff << 2;
               trial   = {2'd0, mplier_ff, 2'b01};
               if (shifted >= trial) begin
                  rem_in    = shifted - trial;
                  mplier_in = {mplier_ff[62:0], 1'b1};
               end else begin
                  rem_in    = shifted;
                  mplier_in = {mplier_ff[62:0], 1'b0};
               end
               last = (cnt_ff == 7'd63);
            end
            default: last = 1'b1;
         endcase
         cnt_in = cnt_ff + 7'd1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ARITH_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
   end

   assign result = (op_ff == ARITH_MUL) ? acc_ff : {64'd0, mplier_ff};
   assign done   = done_ff;

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("arith done without a preceding operation");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start)
      else $error("arith started while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && cmd.start) |=> busy_ff)
      else $error("arith start not taken");

endmodule
